[rtl/char_lcd_nibble_write_sequencer_assert.svh]
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_ASSERT_SVH

// Concurrent check macros: same-cycle implication and next-cycle implication.
// Both sample on clk and are disabled while rst_n is low.

`ifndef NO_ASSERTIONS

`define CLNWS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define CLNWS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CLNWS_ASSERT_NOW(lbl, ante, cons, msg)

`define CLNWS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/clnws_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package clnws_pkg;

    // Request operation codes
    localparam logic [1:0] OP_INIT = 2'd0;
    localparam logic [1:0] OP_CMD  = 2'd1;
    localparam logic [1:0] OP_CHAR = 2'd2;

    // Configuration register indexes
    localparam int         CFG_INDEX_W       = 3;
    localparam logic [2:0] CFG_STROBE_WAIT   = 3'd0;
    localparam logic [2:0] CFG_NIBBLE_WAIT   = 3'd1;
    localparam logic [2:0] CFG_BYTE_GAP_WAIT = 3'd2;
    localparam logic [2:0] CFG_POWERUP_WAIT  = 3'd3;
    localparam logic [2:0] CFG_CLEAR_WAIT    = 3'd4;

    // Register reset values
    localparam logic [15:0] RST_STROBE_WAIT   = 16'd25;
    localparam logic [15:0] RST_NIBBLE_WAIT   = 16'd30000;
    localparam logic [15:0] RST_BYTE_GAP_WAIT = 16'd800;
    localparam logic [15:0] RST_POWERUP_WAIT  = 16'd3200;
    localparam logic [15:0] RST_CLEAR_WAIT    = 16'd10000;

    // Character counter
    localparam int         COUNT_W     = 5;
    localparam logic [4:0] LINE_LENGTH = 5'd16;
    localparam logic [4:0] COUNT_MAX   = 5'd31;

    // Fixed command bytes
    localparam logic [7:0] CMD_LINE_TWO = 8'hC0;

    // Byte steps within a job
    localparam int         STEP_W         = 3;
    localparam logic [2:0] STEP_FIRST     = 3'd0;
    localparam logic [2:0] STEP_WRAP      = 3'd1;
    localparam logic [2:0] INIT_LAST_STEP = 3'd6;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int WAIT_W = 17;

    typedef enum logic [1:0] {
        KIND_INIT = 2'd0,
        KIND_CMD  = 2'd1,
        KIND_CHAR = 2'd2
    } clnws_kind_t;

    typedef enum logic [1:0] {
        PH_CLEAR  = 2'd0,
        PH_DATA   = 2'd1,
        PH_STROBE = 2'd2,
        PH_HOLD   = 2'd3
    } clnws_phase_t;

    typedef struct packed {
        clnws_kind_t kind;
        logic [7:0]  byte_value;
        logic        line_wrap;
    } clnws_job_t;

    typedef struct packed {
        logic [15:0] strobe_wait;
        logic [15:0] nibble_wait;
        logic [15:0] byte_gap_wait;
        logic [15:0] powerup_wait;
        logic [15:0] clear_wait;
    } clnws_cfg_t;

    // Power-up command bytes, by step (step 0 is the pin-clear state)
    function automatic logic [7:0] init_cmd(input logic [2:0] step);
        logic [7:0] cmd;
        unique case (step)
            3'd1:    cmd = 8'h33;
            3'd2:    cmd = 8'h32;
            3'd3:    cmd = 8'h28;
            3'd4:    cmd = 8'h0C;
            3'd5:    cmd = 8'h06;
            3'd6:    cmd = 8'h01;
            default: cmd = 8'h00;
        endcase
        return cmd;
    endfunction

endpackage

`default_nettype wire

[rtl/clnws_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module clnws_front
    import clnws_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_stall,
    input  wire logic [1:0] operation,
    input  wire logic [7:0] byte_value,
    input  wire logic       start_of_text,
    input  wire logic       queue_full,
    output logic            push,
    output clnws_job_t      push_job
);

    logic               accept;
    logic               is_job;
    logic [COUNT_W-1:0] count_base;
    logic [COUNT_W-1:0] count_bumped;
    logic [COUNT_W-1:0] char_count_reg;
    logic [COUNT_W-1:0] char_count_next;

    // Take a beat whenever the queue has room
    assign req_stall = queue_full;
    assign accept    = req_valid && !queue_full;

    // Restart the count on a new string, saturate at the top
    always_comb
    begin
        count_base   = start_of_text ? '0 : char_count_reg;
        count_bumped = (count_base < COUNT_MAX) ? count_base + 1'b1 : count_base;
    end

    // Classify the request and drop the unused code
    always_comb
    begin
        is_job              = 1'b1;
        char_count_next     = char_count_reg;
        push_job.kind       = KIND_CMD;
        push_job.byte_value = byte_value;
        push_job.line_wrap  = 1'b0;
        unique case (operation)
            OP_INIT:
            begin
                push_job.kind = KIND_INIT;
            end
            OP_CMD:
            begin
                push_job.kind = KIND_CMD;
            end
            OP_CHAR:
            begin
                push_job.kind      = KIND_CHAR;
                push_job.line_wrap = (count_base < COUNT_MAX) &&
                                     (count_bumped == LINE_LENGTH);
                if (accept)
                begin
                    char_count_next = count_bumped;
                end
            end
            default:
            begin
                is_job = 1'b0;
            end
        endcase
    end

    assign push = accept && is_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg <= '0;
        end
        else
        begin
            char_count_reg <= char_count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/clnws_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module clnws_queue
    import clnws_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire clnws_job_t push_job,
    input  wire logic       pop,
    output logic            full,
    output logic            head_valid,
    output clnws_job_t      head_job
);

    clnws_job_t             slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   do_pop;

    assign full       = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the job at the tail
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

[rtl/clnws_back.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "char_lcd_nibble_write_sequencer_assert.svh"

module clnws_back
    import clnws_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire clnws_cfg_t         cfg,
    input  wire logic               head_valid,
    input  wire clnws_job_t         head_job,
    output logic                    pop,
    output logic                    pin_valid,
    input  wire logic               pin_stall,
    output logic [3:0]              data_nibble,
    output logic                    reg_select,
    output logic                    enable_line,
    output logic [WAIT_W-1:0]       wait_after,
    output logic                    last_state
);

    clnws_phase_t      phase_reg;
    clnws_phase_t      phase_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              half_reg;
    logic              half_next;

    logic              load;
    logic              powerup;
    logic              final_step;
    logic [7:0]        cur_byte;
    logic              cur_rs;
    logic [15:0]       cur_extra;

    logic [3:0]        gen_nibble;
    logic              gen_rs;
    logic              gen_enable;
    logic [WAIT_W-1:0] gen_wait;
    logic              gen_last;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [3:0]        nibble_reg;
    logic              rs_reg;
    logic              enable_reg;
    logic [WAIT_W-1:0] wait_reg;
    logic              last_reg;

    // Fill the output register when empty or being taken
    assign load = head_valid && (!out_valid_reg || !pin_stall);

    // Pick the byte, RS level and extra gap for the current step
    always_comb
    begin
        powerup    = 1'b0;
        final_step = 1'b0;
        cur_byte   = head_job.byte_value;
        cur_rs     = 1'b0;
        cur_extra  = '0;
        unique case (head_job.kind)
            KIND_INIT:
            begin
                powerup    = (step_reg == STEP_FIRST);
                final_step = (step_reg == INIT_LAST_STEP);
                cur_byte   = init_cmd(step_reg);
                cur_extra  = final_step ? cfg.clear_wait : cfg.byte_gap_wait;
            end
            KIND_CMD:
            begin
                final_step = 1'b1;
            end
            KIND_CHAR:
            begin
                final_step = head_job.line_wrap ? (step_reg == STEP_WRAP) : 1'b1;
                cur_rs     = (step_reg == STEP_FIRST);
                cur_byte   = (step_reg == STEP_FIRST) ? head_job.byte_value
                                                      : CMD_LINE_TWO;
                cur_extra  = cfg.byte_gap_wait;
            end
            default:
            begin
                final_step = 1'b1;
            end
        endcase
    end

    // Build the pin state and step to the next one
    always_comb
    begin
        gen_nibble = half_reg ? cur_byte[3:0] : cur_byte[7:4];
        gen_rs     = cur_rs;
        gen_enable = 1'b0;
        gen_wait   = '0;
        gen_last   = 1'b0;
        phase_next = phase_reg;
        step_next  = step_reg;
        half_next  = half_reg;

        if (powerup)
        begin
            gen_nibble = '0;
            gen_rs     = 1'b0;
            gen_wait   = {1'b0, cfg.powerup_wait};
        end
        else
        begin
            unique case (phase_reg)
                PH_CLEAR:
                begin
                    gen_nibble = '0;
                    gen_rs     = 1'b0;
                end
                PH_DATA:
                begin
                    gen_wait = '0;
                end
                PH_STROBE:
                begin
                    gen_enable = 1'b1;
                    gen_wait   = {1'b0, cfg.strobe_wait};
                end
                PH_HOLD:
                begin
                    gen_wait = {1'b0, cfg.nibble_wait} +
                               (half_reg ? {1'b0, cur_extra} : '0);
                    gen_last = final_step && half_reg;
                end
                default:
                begin
                    gen_wait = '0;
                end
            endcase
        end

        if (load)
        begin
            if (gen_last)
            begin
                phase_next = PH_CLEAR;
                step_next  = STEP_FIRST;
                half_next  = 1'b0;
            end
            else if (powerup)
            begin
                step_next = step_reg + 1'b1;
            end
            else if (phase_reg == PH_HOLD)
            begin
                phase_next = PH_CLEAR;
                half_next  = !half_reg;
                if (half_reg)
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            else
            begin
                phase_next = clnws_phase_t'(phase_reg + 1'b1);
            end
        end
    end

    // Release the job after its final pin state
    assign pop = load && gen_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CLEAR;
            step_reg  <= STEP_FIRST;
            half_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
            half_reg  <= half_next;
        end
    end

    // Hold the beat while stalled, drop it once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!pin_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            nibble_reg <= gen_nibble;
            rs_reg     <= gen_rs;
            enable_reg <= gen_enable;
            wait_reg   <= gen_wait;
            last_reg   <= gen_last;
        end
    end

    assign pin_valid   = out_valid_reg;
    assign data_nibble = nibble_reg;
    assign reg_select  = rs_reg;
    assign enable_line = enable_reg;
    assign wait_after  = wait_reg;
    assign last_state  = last_reg;

    `CLNWS_ASSERT_NOW(a_idle_counters_home, !head_valid,
        (phase_reg == PH_CLEAR) && (step_reg == STEP_FIRST) && !half_reg,
        "sequence counters moved with no job at the head")
    `CLNWS_ASSERT_NEXT(a_counters_reset_after_last, pop,
        (phase_reg == PH_CLEAR) && (step_reg == STEP_FIRST) && !half_reg,
        "sequence counters not cleared after the final pin state")
    `CLNWS_ASSERT_NOW(a_step_in_range, 1'b1, step_reg <= INIT_LAST_STEP,
        "byte step ran past the power-up sequence")
    `CLNWS_ASSERT_NOW(a_strobe_not_last, pin_valid && enable_line, !last_state,
        "request ended with enable held high")

endmodule

`default_nettype wire

[rtl/char_lcd_nibble_write_sequencer.sv]
// Character LCD 4-bit write sequencer.
// Request channel (req_valid / req_stall): operation 0 runs the power-up
// sequence, 1 sends byte_value as a command, 2 sends it as a character;
// start_of_text restarts the line counter. Code 3 is taken and dropped.
// Pin channel (pin_valid / pin_stall): one beat per LCD pin state with
// data_nibble, reg_select, enable_line, the wait_after count, and
// last_state on the final beat of each request.
// Config channel (cfg_valid / cfg_ready): cfg_index picks a wait register,
// cfg_data is written; ready is always high, unknown indexes are ignored.
// Throughput: one pin state per cycle while pin_stall is low; a command is
// 8 pin states, a character 8 (16 when it wraps to line two) and power-up 49.
// The pin sequencer emitting one state per cycle sets this rate.
// A taken request enters the job queue, then its first beat is registered.
// A four-entry job queue lets requests be taken while earlier ones play out.
// A stalled beat holds; the queue fills and then stalls the request side.
// Reset empties the queue, clears the character count and restores the
// default wait values.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_nibble_write_sequencer
    import clnws_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    output logic                        req_stall,
    input  wire logic [1:0]             operation,
    input  wire logic [7:0]             byte_value,
    input  wire logic                   start_of_text,
    output logic                        pin_valid,
    input  wire logic                   pin_stall,
    output logic [3:0]                  data_nibble,
    output logic                        reg_select,
    output logic                        enable_line,
    output logic [WAIT_W-1:0]           wait_after,
    output logic                        last_state,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [15:0]            cfg_data
);

    clnws_cfg_t cfg_reg;
    clnws_cfg_t cfg_next;
    logic       push;
    clnws_job_t push_job;
    logic       queue_full;
    logic       pop;
    logic       head_valid;
    clnws_job_t head_job;

    assign cfg_ready = 1'b1;

    // Decode register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_STROBE_WAIT:   cfg_next.strobe_wait   = cfg_data;
                CFG_NIBBLE_WAIT:   cfg_next.nibble_wait   = cfg_data;
                CFG_BYTE_GAP_WAIT: cfg_next.byte_gap_wait = cfg_data;
                CFG_POWERUP_WAIT:  cfg_next.powerup_wait  = cfg_data;
                CFG_CLEAR_WAIT:    cfg_next.clear_wait    = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.strobe_wait   <= RST_STROBE_WAIT;
            cfg_reg.nibble_wait   <= RST_NIBBLE_WAIT;
            cfg_reg.byte_gap_wait <= RST_BYTE_GAP_WAIT;
            cfg_reg.powerup_wait  <= RST_POWERUP_WAIT;
            cfg_reg.clear_wait    <= RST_CLEAR_WAIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    clnws_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .operation     (operation),
        .byte_value    (byte_value),
        .start_of_text (start_of_text),
        .queue_full    (queue_full),
        .push          (push),
        .push_job      (push_job)
    );

    clnws_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    clnws_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head_valid  (head_valid),
        .head_job    (head_job),
        .pop         (pop),
        .pin_valid   (pin_valid),
        .pin_stall   (pin_stall),
        .data_nibble (data_nibble),
        .reg_select  (reg_select),
        .enable_line (enable_line),
        .wait_after  (wait_after),
        .last_state  (last_state)
    );

endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import clnws_pkg::*;

    // Operation code that the block takes and drops
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Register indexes with no register behind them
    localparam logic [2:0] CFG_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] CFG_LAST_UNUSED  = 3'd7;

    // Power-up command bytes, first byte in the top bits
    localparam logic [47:0] POWERUP_SEQ = 48'h33_32_28_0C_06_01;
    localparam int          POWERUP_LEN = 6;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 10;
    localparam int CYCLE_LIMIT     = 500000;

    typedef struct packed {
        logic [3:0]        nibble;
        logic              rs;
        logic              en;
        logic [WAIT_W-1:0] hold;
        logic              is_last;
    } pin_state_t;

    // Predicts the LCD pin states of each request and checks them in order
    class pin_state_scoreboard;
        pin_state_t  expected_pins[$];
        pin_state_t  burst[$];
        logic [15:0] strobe_wait;
        logic [15:0] nibble_wait;
        logic [15:0] byte_gap_wait;
        logic [15:0] powerup_wait;
        logic [15:0] clear_wait;
        logic [4:0]  char_count;
        int          mismatches;

        function new();
            strobe_wait   = RST_STROBE_WAIT;
            nibble_wait   = RST_NIBBLE_WAIT;
            byte_gap_wait = RST_BYTE_GAP_WAIT;
            powerup_wait  = RST_POWERUP_WAIT;
            clear_wait    = RST_CLEAR_WAIT;
            char_count    = '0;
            mismatches    = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                CFG_STROBE_WAIT:   strobe_wait   = data;
                CFG_NIBBLE_WAIT:   nibble_wait   = data;
                CFG_BYTE_GAP_WAIT: byte_gap_wait = data;
                CFG_POWERUP_WAIT:  powerup_wait  = data;
                CFG_CLEAR_WAIT:    clear_wait    = data;
                default:           ;
            endcase
        endfunction

        function void add_state(logic [3:0] nib, logic rs, logic en, logic [WAIT_W-1:0] hold);
            pin_state_t st;
            st.nibble  = nib;
            st.rs      = rs;
            st.en      = en;
            st.hold    = hold;
            st.is_last = 1'b0;
            burst.push_back(st);
        endfunction

        // Clear, set data, raise enable, drop enable
        function void add_nibble(logic [3:0] nib, logic rs, logic [15:0] extra);
            add_state(4'h0, 1'b0, 1'b0, '0);
            add_state(nib, rs, 1'b0, '0);
            add_state(nib, rs, 1'b1, {1'b0, strobe_wait});
            add_state(nib, rs, 1'b0, {1'b0, nibble_wait} + {1'b0, extra});
        endfunction

        function void add_byte(logic [7:0] b, logic rs, logic [15:0] extra);
            add_nibble(b[7:4], rs, 16'h0000);
            add_nibble(b[3:0], rs, extra);
        endfunction

        function void note_request(logic [1:0] op, logic [7:0] b, logic sot);
            pin_state_t tail;
            burst.delete();
            case (op)
                OP_INIT: begin
                    add_state(4'h0, 1'b0, 1'b0, {1'b0, powerup_wait});
                    for (int i = 0; i < POWERUP_LEN; i++)
                        add_byte(POWERUP_SEQ[47 - 8 * i -: 8], 1'b0,
                                 (i == POWERUP_LEN - 1) ? clear_wait : byte_gap_wait);
                end
                OP_CMD: add_byte(b, 1'b0, 16'h0000);
                OP_CHAR: begin
                    if (sot)
                        char_count = '0;
                    add_byte(b, 1'b1, byte_gap_wait);
                    // Count up to saturation; wrap to line two exactly once
                    if (char_count < COUNT_MAX) begin
                        char_count = char_count + 5'd1;
                        if (char_count == LINE_LENGTH)
                            add_byte(CMD_LINE_TWO, 1'b0, byte_gap_wait);
                    end
                end
                default: ;
            endcase
            if (burst.size() == 0)
                return;
            tail = burst.pop_back();
            tail.is_last = 1'b1;
            burst.push_back(tail);
            foreach (burst[i])
                expected_pins.push_back(burst[i]);
        endfunction

        function void check_pin_state(logic [3:0] nib, logic rs, logic en,
                                      logic [WAIT_W-1:0] hold, logic is_last);
            pin_state_t want;
            if (expected_pins.size() == 0) begin
                $error("pin state beat with nothing expected: nibble %0h rs %0b en %0b",
                       nib, rs, en);
                mismatches++;
                return;
            end
            want = expected_pins.pop_front();
            if (nib !== want.nibble) begin
                $error("data_nibble: expected %0h, got %0h", want.nibble, nib);
                mismatches++;
            end
            if (rs !== want.rs) begin
                $error("reg_select: expected %0b, got %0b", want.rs, rs);
                mismatches++;
            end
            if (en !== want.en) begin
                $error("enable_line: expected %0b, got %0b", want.en, en);
                mismatches++;
            end
            if (hold !== want.hold) begin
                $error("wait_after: expected %0d, got %0d", want.hold, hold);
                mismatches++;
            end
            if (is_last !== want.is_last) begin
                $error("last_state: expected %0b, got %0b", want.is_last, is_last);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_pins.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   req_valid;
    logic                   req_stall;
    logic [1:0]             operation;
    logic [7:0]             byte_value;
    logic                   start_of_text;
    logic                   pin_valid;
    logic                   pin_stall;
    logic [3:0]             data_nibble;
    logic                   reg_select;
    logic                   enable_line;
    logic [WAIT_W-1:0]      wait_after;
    logic                   last_state;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [15:0]            cfg_data;

    pin_state_scoreboard sb;
    bit                  quiet;
    int                  hold_off_asks;
    int                  items_sent;
    int                  cycles;

    char_lcd_nibble_write_sequencer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .operation     (operation),
        .byte_value    (byte_value),
        .start_of_text (start_of_text),
        .pin_valid     (pin_valid),
        .pin_stall     (pin_stall),
        .data_nibble   (data_nibble),
        .reg_select    (reg_select),
        .enable_line   (enable_line),
        .wait_after    (wait_after),
        .last_state    (last_state),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Pin side: random stall bursts, plus a long hold-off on request
    initial
    begin : pin_receiver
        int stall_left;
        int hold_left;
        int asks_seen;
        stall_left = 0;
        hold_left  = 0;
        asks_seen  = 0;
        pin_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_asks != asks_seen)
            begin
                asks_seen = hold_off_asks;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pin_stall = 1'b1;
            end
            else if (quiet)
            begin
                stall_left = 0;
                pin_stall  = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pin_stall = 1'b1;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 4);
                pin_stall  = 1'b1;
            end
            else
                pin_stall = 1'b0;
        end
    end

    // Check every pin state beat that is taken
    always @(posedge clk)
    begin
        if (rst_n && pin_valid && !pin_stall)
            sb.check_pin_state(data_nibble, reg_select, enable_line, wait_after, last_state);
    end

    // Offer one request beat; returns at a falling edge with valid still high
    task automatic send_request(logic [1:0] op, logic [7:0] b, logic sot);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 5);
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        operation     = op;
        byte_value    = b;
        start_of_text = sot;
        req_valid     = 1'b1;
        forever
        begin
            @(posedge clk);
            if (!req_stall)
                break;
            @(negedge clk);
        end
        sb.note_request(op, b, sot);
        if (op != OP_UNUSED)
            items_sent++;
        @(negedge clk);
    endtask

    // Drop the request side and wait for every expected pin state
    task automatic settle_pins();
        req_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_wait_reg(logic [2:0] idx, logic [15:0] data);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
            @(negedge clk);
        end
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
        @(negedge clk);
    endtask

    task automatic write_all_regs(logic [15:0] data);
        write_wait_reg(CFG_STROBE_WAIT, data);
        write_wait_reg(CFG_NIBBLE_WAIT, data);
        write_wait_reg(CFG_BYTE_GAP_WAIT, data);
        write_wait_reg(CFG_POWERUP_WAIT, data);
        write_wait_reg(CFG_CLEAR_WAIT, data);
    endtask

    // Mostly well-formed strings, with commands, power-up runs and noise mixed in
    task automatic run_traffic(int budget, bit pause_midway);
        int stop_at;
        int pick;
        int len;
        bit paused;
        stop_at = items_sent + budget;
        paused  = 1'b0;
        while (items_sent < stop_at)
        begin
            if (pause_midway && !paused && items_sent >= stop_at - budget / 2)
            begin
                paused = 1'b1;
                settle_pins();
            end
            pick = $urandom_range(0, 99);
            if (pick < 55 || (pick >= 88 && pick < 95))
            begin
                // Full string, or a continuation that never restarts the count
                len = $urandom_range(1, 40);
                if (len > stop_at - items_sent)
                    len = stop_at - items_sent;
                for (int i = 0; i < len; i++)
                    send_request(OP_CHAR, 8'($urandom), (i == 0) && (pick < 55));
            end
            else if (pick < 70)
                send_request(OP_CMD, 8'($urandom), 1'($urandom));
            else if (pick < 78)
                send_request(OP_INIT, 8'($urandom), 1'($urandom));
            else if (pick < 88)
                send_request(OP_CHAR, 8'($urandom), 1'($urandom));
            else
                send_request(OP_UNUSED, 8'($urandom), 1'($urandom));
        end
    endtask

    initial
    begin
        sb            = new();
        quiet         = 1'b0;
        hold_off_asks = 0;
        items_sent    = 0;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        operation     = OP_INIT;
        byte_value    = 8'h00;
        start_of_text = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_STROBE_WAIT;
        cfg_data      = 16'h0000;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reset waits, byte extremes, dropped code, line wrap
        send_request(OP_INIT, 8'h00, 1'b0);
        send_request(OP_CMD, 8'h00, 1'b0);
        send_request(OP_CMD, 8'hFF, 1'b1);
        send_request(OP_CHAR, 8'h00, 1'b1);
        send_request(OP_CHAR, 8'hFF, 1'b0);
        send_request(OP_UNUSED, 8'hFF, 1'b1);
        send_request(OP_UNUSED, 8'h00, 1'b0);
        for (int i = 0; i < 17; i++)
            send_request(OP_CHAR, 8'h30 + 8'(i), i == 0);
        settle_pins();

        // All waits at zero; writes to missing indexes must change nothing
        write_all_regs(16'h0000);
        write_wait_reg(CFG_FIRST_UNUSED, 16'hFFFF);
        write_wait_reg(CFG_LAST_UNUSED, 16'h0000);
        write_wait_reg(3'd6, 16'hFFFF);
        hold_off_asks++;
        run_traffic(70, 1'b0);
        settle_pins();

        // All waits at full scale, so the enable-low sums carry into bit 16
        write_all_regs(16'hFFFF);
        run_traffic(70, 1'b1);
        settle_pins();

        // Random waits
        write_wait_reg(CFG_STROBE_WAIT, 16'($urandom));
        write_wait_reg(CFG_NIBBLE_WAIT, 16'($urandom));
        write_wait_reg(CFG_BYTE_GAP_WAIT, 16'($urandom));
        write_wait_reg(CFG_POWERUP_WAIT, 16'($urandom));
        write_wait_reg(CFG_CLEAR_WAIT, 16'($urandom));
        run_traffic(70, 1'b0);
        settle_pins();

        // Mixed extremes, back to back with no idling
        write_wait_reg(CFG_STROBE_WAIT, 16'h0001);
        write_wait_reg(CFG_NIBBLE_WAIT, 16'hFFFF);
        write_wait_reg(CFG_BYTE_GAP_WAIT, 16'h0001);
        write_wait_reg(CFG_POWERUP_WAIT, 16'h8000);
        write_wait_reg(CFG_CLEAR_WAIT, 16'h7FFF);
        quiet = 1'b1;
        run_traffic(75, 1'b0);
        settle_pins();
        repeat (20) @(negedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
